// ===== src/segsum_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segsum_pkg
// shared types and constants for the segment tree range sum block
// ----------------------------------------------------------------------------
package segsum_pkg;

    localparam int CFG_W   = 11;
    localparam int POS_W   = 11;
    localparam int LAST_W  = 11;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 32;

    localparam logic [CFG_W-1:0] LEAF_COUNT_RESET = 11'd1024;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_UP_READ,
        ST_UP_WRITE,
        ST_Q_WALK,
        ST_Q_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic load;
        logic up_write;
        logic q_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_update;
        logic upd_ok;
        logic parent_nz;
        logic q_empty;
        logic lt;
        logic k_parent_nz;
        logic out_free;
    } status_t;

endpackage

// ===== src/segsum_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segsum_ctrl
// sequencer for clearing, leaf updates, ancestor rebuild and range walks
// ----------------------------------------------------------------------------
module segsum_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  segsum_pkg::status_t status,
    output segsum_pkg::cmd_t    cmd
);
    import segsum_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_update)
                begin
                    state_next = (status.upd_ok && status.parent_nz) ? ST_UP_READ : ST_IDLE;
                end
                else
                begin
                    state_next = status.q_empty ? ST_Q_OUT : ST_Q_WALK;
                end
            end
            ST_UP_READ:
            begin
                state_next = ST_UP_WRITE;
            end
            ST_UP_WRITE:
            begin
                state_next = status.k_parent_nz ? ST_UP_READ : ST_IDLE;
            end
            ST_Q_WALK:
            begin
                if (!status.lt)
                begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.load       = (state_reg == ST_DECODE);
        cmd.up_write   = (state_reg == ST_UP_WRITE);
        cmd.q_step     = (state_reg == ST_Q_WALK);
        cmd.load_out   = (state_reg == ST_Q_OUT) && status.out_free;
        in_stall       = (state_reg != ST_IDLE);
    end

endmodule

// ===== src/segsum_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segsum_dp
// node store, index registers, accumulator and output register
// ----------------------------------------------------------------------------
module segsum_dp #(
    parameter int MAX_LEAVES = 1024,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic        [segsum_pkg::CFG_W-1:0]     leaf_count,
    input  logic                                    opcode,
    input  logic        [segsum_pkg::POS_W-1:0]     position,
    input  logic signed [segsum_pkg::LAST_W-1:0]    last_leaf,
    input  logic signed [segsum_pkg::VALUE_W-1:0]   new_value,
    input  segsum_pkg::cmd_t                        cmd,
    output segsum_pkg::status_t                     status,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [segsum_pkg::OUT_W-1:0]     range_sum
);
    import segsum_pkg::*;

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int RW    = IDX_W + 1;
    localparam int NW    = $clog2(MAX_LEAVES + 1);
    localparam int CW    = ((NW > CFG_W) ? NW : CFG_W) + 1;
    localparam int XW    = ((RW > CW) ? RW : CW) + 1;

    logic [SUM_WIDTH-1:0] mem [DEPTH];

    logic [CFG_W-1:0]      leaf_count_reg;
    logic                  op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [LAST_W-1:0]     last_reg;
    logic [SUM_WIDTH-1:0]  val_reg;
    logic [IDX_W-1:0]      k_reg;
    logic [RW-1:0]         l_reg;
    logic [RW-1:0]         r_reg;
    logic [SUM_WIDTH-1:0]  acc_reg;
    logic                  pend_a_reg;
    logic                  pend_b_reg;
    logic [SUM_WIDTH-1:0]  rd_a_reg;
    logic [SUM_WIDTH-1:0]  rd_b_reg;
    logic [IDX_W-1:0]      clr_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_sum_reg;

    logic [XW-1:0]         lc_x;
    logic [XW-1:0]         n_x;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         last_x;
    logic [XW-1:0]         hi_x;
    logic [XW-1:0]         leaf_x;
    logic [XW-1:0]         r0_x;
    logic                  last_neg;
    logic                  pos_in;
    logic signed [63:0]    val_wide;
    logic [63:0]           acc_wide;
    logic [IDX_W-1:0]      child_a;
    logic [IDX_W-1:0]      child_b;
    logic [RW-1:0]         l_next;
    logic [RW-1:0]         r_dec;
    logic [IDX_W-1:0]      addr_a;
    logic [IDX_W-1:0]      addr_b;
    logic                  we;
    logic [IDX_W-1:0]      wa;
    logic [SUM_WIDTH-1:0]  wd;
    logic [SUM_WIDTH-1:0]  add_a;
    logic [SUM_WIDTH-1:0]  add_b;
    logic [SUM_WIDTH-1:0]  acc_next;
    logic                  lt;

    // effective leaf count and range decode
    always_comb
    begin
        lc_x     = XW'(leaf_count_reg);
        if (lc_x == '0)
        begin
            n_x = XW'(1);
        end
        else if (lc_x > XW'(MAX_LEAVES))
        begin
            n_x = XW'(MAX_LEAVES);
        end
        else
        begin
            n_x = lc_x;
        end
        pos_x    = XW'(pos_reg);
        last_neg = last_reg[LAST_W-1];
        last_x   = XW'(last_reg[LAST_W-2:0]);
        hi_x     = (last_x > n_x - XW'(1)) ? (n_x - XW'(1)) : last_x;
        pos_in   = (pos_x < n_x);
        leaf_x   = pos_x + n_x;
        r0_x     = hi_x + XW'(1) + n_x;
    end

    assign val_wide = 64'(new_value);
    assign acc_wide = 64'(acc_reg);

    assign child_a = IDX_W'({k_reg, 1'b0});
    assign child_b = IDX_W'({k_reg, 1'b1});
    assign lt      = (l_reg < r_reg);
    assign l_next  = (l_reg + RW'(l_reg[0])) >> 1;
    assign r_dec   = r_reg - RW'(1);
    assign addr_a  = cmd.q_step ? l_reg[IDX_W-1:0] : child_a;
    assign addr_b  = cmd.q_step ? r_dec[IDX_W-1:0] : child_b;

    assign add_a    = pend_a_reg ? rd_a_reg : '0;
    assign add_b    = pend_b_reg ? rd_b_reg : '0;
    assign acc_next = acc_reg + add_a + add_b;

    // store write port
    always_comb
    begin
        we = 1'b0;
        wa = k_reg;
        wd = rd_a_reg + rd_b_reg;
        priority if (cmd.clear_step)
        begin
            we = 1'b1;
            wa = clr_reg;
            wd = '0;
        end
        else if (cmd.load && (op_reg == OP_SET) && pos_in)
        begin
            we = 1'b1;
            wa = leaf_x[IDX_W-1:0];
            wd = val_reg;
        end
        else if (cmd.up_write)
        begin
            we = 1'b1;
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            pos_reg  <= position;
            last_reg <= last_leaf;
            val_reg  <= val_wide[SUM_WIDTH-1:0];
        end
        if (cmd.load)
        begin
            k_reg      <= leaf_x[IDX_W:1];
            l_reg      <= leaf_x[RW-1:0];
            r_reg      <= r0_x[RW-1:0];
            acc_reg    <= '0;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
        end
        if (cmd.up_write)
        begin
            k_reg <= k_reg >> 1;
        end
        if (cmd.q_step)
        begin
            acc_reg <= acc_next;
            if (lt)
            begin
                pend_a_reg <= l_reg[0];
                pend_b_reg <= r_reg[0];
                l_reg      <= l_next;
                r_reg      <= r_reg >> 1;
            end
            else
            begin
                pend_a_reg <= 1'b0;
                pend_b_reg <= 1'b0;
            end
        end
        if (cmd.load_out)
        begin
            out_sum_reg <= acc_wide[OUT_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= LEAF_COUNT_RESET;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                leaf_count_reg <= leaf_count;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status             = '0;
        status.clr_done    = (clr_reg == IDX_W'(DEPTH - 1));
        status.is_update   = (op_reg == OP_SET);
        status.upd_ok      = pos_in;
        status.parent_nz   = (leaf_x[IDX_W:1] != '0);
        status.q_empty     = last_neg || !pos_in || (hi_x < pos_x);
        status.lt          = lt;
        status.k_parent_nz = (k_reg[IDX_W-1:1] != '0);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign range_sum = out_sum_reg;

endmodule

// ===== src/segment_tree_range_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// iterative segment tree with point update and inclusive range sum query
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one item per transfer:
//   opcode set writes new_value into leaf position and rebuilds the
//   ancestors, opcode query returns the sum of leaves position..last_leaf
//   on the output channel (out_valid / out_stall), zero for an empty range
//   leaf_count is written over its own valid / ready port; the user must
//   write it only while idle, which the block does not enforce; cfg_ready
//   is always high
//   flow: one item at a time; an update reads a node pair and writes back
//   per tree level on the two-read, one-write node store; a query reads
//   one node pair per level, result on out
//   reset: a clearing pass zeroes the node store, one entry per cycle,
//   with in_stall high until it completes
//   stall: the result sits in an output register; a new item is accepted
//   while it waits, and a later query holds in its final state until the
//   register is free
// ----------------------------------------------------------------------------
module segment_tree_range_sum #(
    parameter int MAX_LEAVES = 1024,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration write
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [segsum_pkg::CFG_W-1:0]     leaf_count,
    // item input
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    opcode,
    input  logic        [segsum_pkg::POS_W-1:0]     position,
    input  logic signed [segsum_pkg::LAST_W-1:0]    last_leaf,
    input  logic signed [segsum_pkg::VALUE_W-1:0]   new_value,
    // result output
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [segsum_pkg::OUT_W-1:0]     range_sum
);
    import segsum_pkg::*;

    cmd_t    cmd;
    status_t status;

    // the register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: clear pass, decode, level walk
    segsum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // node store and arithmetic
    segsum_dp #(
        .MAX_LEAVES (MAX_LEAVES),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .leaf_count (leaf_count),
        .opcode     (opcode),
        .position   (position),
        .last_leaf  (last_leaf),
        .new_value  (new_value),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .range_sum  (range_sum)
    );

endmodule

// ===== src/segsum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segsum_checker
// port level checks for the segment tree range sum block
// ----------------------------------------------------------------------------
module segsum_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [segsum_pkg::OUT_W-1:0]  range_sum
);

    // a held result stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(range_sum))
        else $error("result changed while stalled");

    // one item in flight: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

    // no result can appear in the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared before decode");

endmodule

bind segment_tree_range_sum segsum_checker u_chk (.*);

// ===== test/segsum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segsum_scoreboard
// keeps its own copy of the node store and the leaf count, follows every
// transfer on the three channels and compares each range sum with its
// prediction
// ----------------------------------------------------------------------------
module segsum_scoreboard (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic        [segsum_pkg::CFG_W-1:0]   leaf_count,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  opcode,
    input  logic        [segsum_pkg::POS_W-1:0]   position,
    input  logic signed [segsum_pkg::LAST_W-1:0]  last_leaf,
    input  logic signed [segsum_pkg::VALUE_W-1:0] new_value,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [segsum_pkg::OUT_W-1:0]   range_sum,
    output int                                    mismatch_count,
    output int                                    sums_owed
);
    import segsum_pkg::*;

    localparam int NODE_COUNT = 2048;

    logic [OUT_W-1:0] tree_nodes [0:NODE_COUNT-1];
    logic [CFG_W-1:0] leaves_cfg;
    logic [OUT_W-1:0] expected_sums [$];
    logic [OUT_W-1:0] wanted_sum;

    // leaf count saturated to 1 .. 1024
    function automatic int unsigned leaves_in_use();
        if (leaves_cfg == '0)
            return 1;
        if (leaves_cfg > 11'd1024)
            return 1024;
        return 32'(leaves_cfg);
    endfunction

    function automatic void write_leaf(logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        int unsigned n;
        int unsigned k;
        n = leaves_in_use();
        if (pos >= n)
            return;
        k = pos + n;
        tree_nodes[k] = val;
        k = k >> 1;
        while (k != 0)
        begin
            tree_nodes[k] = tree_nodes[2*k] + tree_nodes[2*k+1];
            k = k >> 1;
        end
    endfunction

    function automatic logic [OUT_W-1:0] predict_range_sum(logic [POS_W-1:0] pos,
                                                           logic signed [LAST_W-1:0] hi_leaf);
        int unsigned n;
        int          hi_i;
        int unsigned l;
        int unsigned r;
        logic [OUT_W-1:0] acc;
        n    = leaves_in_use();
        hi_i = int'(hi_leaf);
        acc  = '0;
        if (hi_i < 0 || pos >= n)
            return '0;
        if (hi_i > int'(n) - 1)
            hi_i = int'(n) - 1;
        if (hi_i < int'(pos))
            return '0;
        l = pos + n;
        r = hi_i + 1 + n;
        while (l < r)
        begin
            if (l[0])
            begin
                acc = acc + tree_nodes[l];
                l++;
            end
            if (r[0])
            begin
                r--;
                acc = acc + tree_nodes[r];
            end
            l = l >> 1;
            r = r >> 1;
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
                tree_nodes[i] = '0;
            leaves_cfg = LEAF_COUNT_RESET;
            expected_sums.delete();
            mismatch_count = 0;
            sums_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                leaves_cfg = leaf_count;
            // results first, so a query accepted at the same edge queues behind
            if (out_valid && !out_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("range_sum: no query outstanding, actual %0d", range_sum);
                    mismatch_count++;
                end
                else
                begin
                    wanted_sum = expected_sums.pop_front();
                    if (range_sum !== wanted_sum)
                    begin
                        $error("range_sum: expected %0d, actual %0d",
                               $signed(wanted_sum), range_sum);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (opcode == OP_QUERY)
                    expected_sums = {expected_sums, predict_range_sum(position, last_leaf)};
                else
                    write_leaf(position, new_value);
            end
            sums_owed = expected_sums.size();
        end
    end

endmodule

// ===== test/segment_tree_range_sum_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum_test
// drives point updates and range sum queries into the segment tree under
// several leaf counts, with random idle gaps and output stalls; a checker
// beside the block predicts every range sum and counts mismatches
// ----------------------------------------------------------------------------
module segment_tree_range_sum_test;

    import segsum_pkg::*;

    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 40;     // margin for an update still walking the tree
    localparam int TAIL_CYCLES     = 50;
    localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
    localparam int TIMEOUT_NS      = 3_000_000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic        [CFG_W-1:0]   leaf_count;
    logic                      in_valid;
    logic                      in_stall;
    logic                      opcode;
    logic        [POS_W-1:0]   position;
    logic signed [LAST_W-1:0]  last_leaf;
    logic signed [VALUE_W-1:0] new_value;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [OUT_W-1:0]   range_sum;

    int          mismatches;
    int          owed;
    logic        no_idle;      // stretch with no gaps on either side
    int          hold_asks;    // long receiver hold-offs requested so far
    int unsigned span;         // effective leaf count, used to shape stimulus

    segment_tree_range_sum dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .leaf_count (leaf_count),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .position   (position),
        .last_leaf  (last_leaf),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .range_sum  (range_sum)
    );

    segsum_scoreboard u_scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .leaf_count     (leaf_count),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .position       (position),
        .last_leaf      (last_leaf),
        .new_value      (new_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .range_sum      (range_sum),
        .mismatch_count (mismatches),
        .sums_owed      (owed)
    );

    // 4 ns clock
    initial
        clk = 1'b0;
    always
        #2 clk = ~clk;

    // hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // mostly short gaps, a few long ones, none in a quiet stretch
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver side: random stall bursts, plus the long hold-off on request
    initial
    begin
        int len;
        int holds_done;
        holds_done = 0;
        out_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_asks != holds_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else if (!no_idle && $urandom_range(0, 99) < 30)
            begin
                out_stall <= 1'b1;
                len = idle_len();
                repeat (len) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // one item transfer; valid stays high afterwards until the next negedge
    task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                             input logic signed [LAST_W-1:0] hi_leaf,
                             input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        position  <= pos;
        last_leaf <= hi_leaf;
        new_value <= val;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // write leaf_count once the tree has drained and settled
    task automatic set_leaf_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed != 0)
            @(posedge clk);
        // updates give no result and may still be walking the tree
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        leaf_count <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (value == '0)
            span = 1;
        else if (value > 11'd1024)
            span = 1024;
        else
            span = value;
    endtask

    // random item shaped around the current leaf count
    task automatic send_random();
        int          r;
        int unsigned pos;
        int          hi;
        logic        op;
        logic [31:0] val;
        op = ($urandom_range(0, 99) < 50) ? OP_SET : OP_QUERY;

        r = $urandom_range(0, 99);
        if (r < 80)
            pos = $urandom_range(0, span - 1);
        else if (r < 88)
            pos = r[0] ? 0 : span - 1;
        else
            pos = $urandom_range(span, 2047);    // outside the leaves

        r = $urandom_range(0, 99);
        if (r < 65)
            hi = (pos < span) ? $urandom_range(pos, span - 1) : $urandom_range(0, 1023);
        else if (r < 75)
            hi = $urandom_range(span - 1, 1023); // clipped to the top leaf
        else if (r < 85)
            hi = (pos == 0) ? 0 : $urandom_range(0, (pos > 1024) ? 1023 : pos - 1);
        else if (r < 93)
            hi = -int'($urandom_range(1, 1024));
        else
            hi = $urandom_range(0, 2047) - 1024;

        r = $urandom_range(0, 99);
        if (r < 70)
            val = $urandom;
        else if (r < 80)
            val = $urandom_range(0, 20) - 10;
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = 32'hFFFF_FFFF;
                default: val = 32'h0000_0000;
            endcase
        end
        else
            val = $urandom;

        send_item(op, pos[POS_W-1:0], hi[LAST_W-1:0], val);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_leaves [10];
        phase_leaves = '{11'd13, 11'd0, 11'd1024, 11'd2, 11'd1, 11'd2047,
                         11'd600, 11'd64, 11'd1023, 11'd5};

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        leaf_count = LEAF_COUNT_RESET;
        in_valid   = 1'b0;
        opcode     = OP_SET;
        position   = '0;
        last_leaf  = '0;
        new_value  = '0;
        no_idle    = 1'b0;
        hold_asks  = 0;
        span       = 1024;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset leaf count of 1024; the first item
        // also waits out the clearing pass
        send_item(OP_QUERY, 11'd0,    11'sd1023,  32'sd0);         // cleared tree
        send_item(OP_SET,   11'd0,    11'sd0,     32'h7FFF_FFFF);  // largest value
        send_item(OP_SET,   11'd1,    11'sd0,     32'sd1);
        send_item(OP_SET,   11'd1023, 11'sd0,     32'h8000_0000);  // smallest value
        send_item(OP_SET,   11'd512,  11'sd0,     -32'sd1);
        send_item(OP_SET,   11'd1024, 11'sd0,     32'sd5);         // beyond the leaves
        send_item(OP_SET,   11'd2047, 11'sd0,     32'h1234_5678);  // beyond, all ones
        send_item(OP_SET,   11'd700,  11'sd0,     32'sd0);
        send_item(OP_QUERY, 11'd0,    11'sd1,     32'sd0);         // sum wraps
        send_item(OP_QUERY, 11'd0,    11'sd1023,  32'sd0);         // whole tree
        send_item(OP_QUERY, 11'd1023, 11'sd1023,  32'sd0);         // top leaf alone
        send_item(OP_QUERY, 11'd0,    11'sd0,     32'sd0);
        send_item(OP_QUERY, 11'd600,  11'sd300,   32'sd0);         // reversed range
        send_item(OP_QUERY, 11'd0,    -11'sd1,    32'sd0);         // negative end
        send_item(OP_QUERY, 11'd0,    -11'sd1024, 32'sd0);         // most negative end
        send_item(OP_QUERY, 11'd1024, 11'sd1023,  32'sd0);         // first past the leaves
        send_item(OP_QUERY, 11'd2047, -11'sd1,    32'sd0);
        send_item(OP_QUERY, 11'd512,  11'sd512,   32'sd0);
        send_item(OP_QUERY, 11'd1,    11'sd1022,  32'sd0);
        send_item(OP_SET,   11'd3,    11'sd0,     32'h5555_5555);
        send_item(OP_SET,   11'd4,    11'sd0,     32'hAAAA_AAAA);
        send_item(OP_QUERY, 11'd3,    11'sd4,     32'sd0);

        // random phases, each under its own leaf count; the store is kept
        // across changes and read back with the new layout
        for (int p = 0; p < 10; p++)
        begin
            set_leaf_count(phase_leaves[p]);
            no_idle = (p % 3 == 1);
            // the receiver holds off while items keep coming, so the
            // output register fills and the input stalls
            if (p == 2 || p == 5)
                hold_asks++;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        no_idle  = 1'b0;
        while (owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/segsum_pkg.sv
src/segsum_ctrl.sv
src/segsum_dp.sv
src/segment_tree_range_sum.sv
src/segsum_checker.sv
test/segsum_checker.sv
test/segment_tree_range_sum_test.sv
